// ===== hw/rtl/csr_sparse_matrix_entry_update_core_assert.svh =====
// Assertion macros for the sparse matrix entry update core.
// Depends on nothing; included by the top level.
`ifndef CSR_SPARSE_MATRIX_ENTRY_UPDATE_CORE_ASSERT_SVH
`define CSR_SPARSE_MATRIX_ENTRY_UPDATE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSMU_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define CSMU_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define CSMU_ASSERT_IMPL(label, clk, rst_n, prop)
`define CSMU_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== hw/rtl/csmu_pkg.sv =====
// Shared types and constants for the sparse matrix entry update core.
// Depends on nothing.
package csmu_pkg;
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 1024;
    localparam int MAX_NONZEROS = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = $clog2(MAX_NONZEROS);
    localparam int NW = $clog2(MAX_NONZEROS + 1);
    localparam int RPW = $clog2(MAX_ROWS + 1);

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        logic load;
        logic rd_lo;
        logic rd_hi;
        logic set_pos;
        logic rd_col;
        logic step_pos;
        logic overwrite;
        logic shift_rd;
        logic shift_wr;
        logic ins_write;
        logic ptr_clr;
        logic ptr_rd;
        logic ptr_update;
        logic done;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic range_err;
        logic search_end;
        logic found;
        logic greater;
        logic is_zero;
        logic full;
        logic shift_end;
        logic ptr_end;
    } t_stat;
endpackage

// ===== hw/rtl/csmu_datapath.sv =====
// Datapath: row pointers, column and value memories, search and shift counters.
// Depends on csmu_pkg.
module csmu_datapath import csmu_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [RW-1:0]          i_row,
    input  logic [CW-1:0]          i_col,
    input  logic [VALUE_WIDTH-1:0] i_val,
    input  logic [6:0]             i_rows_lim,
    input  logic [10:0]            i_cols_lim,
    output t_stat                  o_stat,
    output logic [NW-1:0]          o_count
);
    logic [NW-1:0]          r_ptr_mem [MAX_ROWS+1];
    logic [CW-1:0]          r_col_mem [MAX_NONZEROS];
    logic [VALUE_WIDTH-1:0] r_val_mem [MAX_NONZEROS];
    logic [NW-1:0]          r_count, r_pos, r_hi, r_j, r_ptr_rd;
    logic [RW-1:0]          r_row;
    logic [CW-1:0]          r_col;
    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_remove;
    logic [RPW-1:0]         r_pj;
    logic [CW-1:0]          r_rd_col;
    logic [VALUE_WIDTH-1:0] r_rd_val;
    logic [RPW-1:0]         w_ptr_addr;
    logic [NW-1:0]          w_hi, w_lo, w_src, w_ptr_wdata;

    assign o_count = r_count;
    assign w_hi = (r_ptr_rd > r_count) ? r_count : r_ptr_rd;
    assign w_lo = (r_ptr_rd > r_hi) ? r_hi : r_ptr_rd;
    assign w_src = r_remove ? r_j + NW'(1) : r_j - NW'(1);
    assign w_ptr_wdata = i_cmd.ptr_clr ? '0
        : (r_remove ? r_ptr_rd - NW'(1) : r_ptr_rd + NW'(1));

    always_comb begin
        if (i_cmd.rd_hi) begin
            w_ptr_addr = RPW'(r_row) + RPW'(1);
        end else if (i_cmd.rd_lo) begin
            w_ptr_addr = RPW'(r_row);
        end else begin
            w_ptr_addr = r_pj;
        end
    end

    always_comb begin
        o_stat.range_err = ({1'b0, i_row} >= i_rows_lim) || ({1'b0, i_col} >= i_cols_lim);
        o_stat.search_end = (r_pos >= r_hi);
        o_stat.found = (r_rd_col == r_col);
        o_stat.greater = (r_rd_col > r_col);
        o_stat.is_zero = (r_val == '0);
        o_stat.full = (r_count >= NW'(MAX_NONZEROS));
        o_stat.shift_end = r_remove ? (r_j + NW'(1) >= r_count) : (r_j <= r_pos);
        o_stat.ptr_end = (r_pj == RPW'(MAX_ROWS));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row <= i_row;
            r_col <= i_col;
            r_val <= i_val;
        end
        if (i_cmd.rd_hi || i_cmd.rd_lo || i_cmd.ptr_rd) r_ptr_rd <= r_ptr_mem[w_ptr_addr];
        if (i_cmd.ptr_clr || i_cmd.ptr_update) r_ptr_mem[r_pj] <= w_ptr_wdata;
        if (i_cmd.rd_lo) r_hi <= w_hi;
        if (i_cmd.set_pos) r_pos <= w_lo;
        if (i_cmd.step_pos) r_pos <= r_pos + NW'(1);
        if (i_cmd.rd_col) r_rd_col <= r_col_mem[r_pos[AW-1:0]];
        if (i_cmd.shift_rd) begin
            r_rd_col <= r_col_mem[w_src[AW-1:0]];
            r_rd_val <= r_val_mem[w_src[AW-1:0]];
        end
        if (i_cmd.shift_wr) begin
            r_col_mem[r_j[AW-1:0]] <= r_rd_col;
            r_val_mem[r_j[AW-1:0]] <= r_rd_val;
        end
        if (i_cmd.overwrite) r_val_mem[r_pos[AW-1:0]] <= r_val;
        if (i_cmd.ins_write) begin
            r_col_mem[r_pos[AW-1:0]] <= r_col;
            r_val_mem[r_pos[AW-1:0]] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_j <= '0;
            r_pj <= '0;
            r_remove <= 1'b0;
        end else begin
            if (i_cmd.set_pos) begin
                r_remove <= (r_val == '0);
                r_pj <= RPW'(r_row) + RPW'(1);
            end
            if (i_cmd.overwrite) begin
                r_j <= r_pos;
            end else if (i_cmd.rd_col) begin
                r_j <= (r_val == '0) ? r_pos : r_count;
            end
            if (i_cmd.shift_wr) r_j <= r_remove ? r_j + NW'(1) : r_j - NW'(1);
            if (i_cmd.ptr_update || i_cmd.ptr_clr) r_pj <= r_pj + RPW'(1);
            if (i_cmd.done && i_cmd.status == ST_OK && i_cmd.ptr_update)
                r_count <= r_remove ? r_count - NW'(1) : r_count + NW'(1);
        end
    end
endmodule

// ===== hw/rtl/csmu_ctrl.sv =====
// Controller state machine sequencing search, shift and pointer update.
// Depends on csmu_pkg.
module csmu_ctrl import csmu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_stat     i_stat,
    output logic      o_busy,
    output t_cmd      o_cmd,
    output logic      o_done,
    output logic [1:0] o_status
);
    typedef enum logic [11:0] {
        S_CLR   = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_HI    = 12'b000000000100,
        S_LO    = 12'b000000001000,
        S_POS   = 12'b000000010000,
        S_READ  = 12'b000000100000,
        S_CMP   = 12'b000001000000,
        S_SRD   = 12'b000010000000,
        S_SWR   = 12'b000100000000,
        S_INS   = 12'b001000000000,
        S_PRD   = 12'b010000000000,
        S_PTR   = 12'b100000000000
    } t_state;
    t_state r_state, n_state;
    logic   r_done, n_done;
    logic [1:0] r_status, n_status;

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_status = r_status;

    always_comb begin
        n_state = r_state;
        n_done = 1'b0;
        n_status = r_status;
        o_cmd = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.ptr_clr = 1'b1;
                if (i_stat.ptr_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.range_err) begin
                        n_done = 1'b1;
                        n_status = ST_RANGE;
                    end else begin
                        n_state = S_HI;
                    end
                end
            end
            S_HI: begin
                o_cmd.rd_hi = 1'b1;
                n_state = S_LO;
            end
            S_LO: begin
                o_cmd.rd_lo = 1'b1;
                n_state = S_POS;
            end
            S_POS: begin
                o_cmd.set_pos = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                if (i_stat.search_end) begin
                    if (i_stat.is_zero) begin
                        n_done = 1'b1;
                        n_status = ST_OK;
                        n_state = S_IDLE;
                    end else if (i_stat.full) begin
                        n_done = 1'b1;
                        n_status = ST_FULL;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_col = 1'b1;
                        n_state = S_SRD;
                    end
                end else begin
                    o_cmd.rd_col = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.found) begin
                    if (i_stat.is_zero) begin
                        n_state = S_SRD;
                    end else begin
                        o_cmd.overwrite = 1'b1;
                        n_done = 1'b1;
                        n_status = ST_OK;
                        n_state = S_IDLE;
                    end
                end else if (i_stat.greater) begin
                    if (i_stat.is_zero) begin
                        n_done = 1'b1;
                        n_status = ST_OK;
                        n_state = S_IDLE;
                    end else if (i_stat.full) begin
                        n_done = 1'b1;
                        n_status = ST_FULL;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SRD;
                    end
                end else begin
                    o_cmd.step_pos = 1'b1;
                    n_state = S_READ;
                end
            end
            S_SRD: begin
                if (i_stat.shift_end) begin
                    n_state = i_stat.is_zero ? S_PRD : S_INS;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state = S_SWR;
                end
            end
            S_SWR: begin
                o_cmd.shift_wr = 1'b1;
                n_state = S_SRD;
            end
            S_INS: begin
                o_cmd.ins_write = 1'b1;
                n_state = S_PRD;
            end
            S_PRD: begin
                o_cmd.ptr_rd = 1'b1;
                n_state = S_PTR;
            end
            S_PTR: begin
                o_cmd.ptr_update = 1'b1;
                if (i_stat.ptr_end) begin
                    o_cmd.done = 1'b1;
                    n_done = 1'b1;
                    n_status = ST_OK;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.status = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_done <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state <= n_state;
            r_done <= n_done;
            r_status <= n_status;
        end
    end
endmodule

// ===== hw/rtl/csr_sparse_matrix_entry_update_core.sv =====
// Top level of the sparse matrix entry update core.
// Depends on csmu_pkg, csmu_ctrl, csmu_datapath and the assertion header.
//
// Usage: a request (row, column, value) is taken at a rising edge with
// start high and busy low. Exactly one result (status, nonzero count)
// appears for one cycle with o_done high; the receiver cannot stall it.
// An out-of-range request answers in the cycle right after it is taken,
// and busy stays low, so requests of that kind can follow back to back.
// Otherwise the block reads the two row pointers, scans the row one column
// entry at a time with a read and a compare state each, then for an insert
// or removal moves every later entry with a read and a write state each,
// and finally adjusts the row pointers above the row with a read and a write
// state each. Configuration (i_cfg_we, i_cfg_index, i_cfg_data) is written
// by the user only while idle; the block itself does not enforce it. Values
// above the maximum saturate, though a row value keeps only its low 7 bits
// first. Reset clears the count at once and then clears all MAX_ROWS+1 row
// pointers in a pass with busy high; the entry memories need no clearing.
`include "csr_sparse_matrix_entry_update_core_assert.svh"
module csr_sparse_matrix_entry_update_core import csmu_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [RW-1:0]          i_row_number,
    input  logic [CW-1:0]          i_column_number,
    input  logic [31:0]            i_entry_value,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [10:0]            i_cfg_data,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [NW-1:0]          o_nonzero_count
);
    logic [6:0]  r_rows;
    logic [10:0] r_cols;
    logic [6:0]  w_rows_lim;
    logic [10:0] w_cols_lim;
    t_cmd        w_cmd;
    t_stat       w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 7'(MAX_ROWS);
            r_cols <= 11'(MAX_COLS);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ROWS) r_rows <= i_cfg_data[6:0];
            if (i_cfg_index == CFG_COLS) r_cols <= i_cfg_data;
        end
    end
    assign w_rows_lim = (r_rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : r_rows;
    assign w_cols_lim = (r_cols > 11'(MAX_COLS)) ? 11'(MAX_COLS) : r_cols;

    csmu_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_stat(w_stat),
        .o_busy(busy), .o_cmd(w_cmd), .o_done, .o_status
    );
    csmu_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_row(i_row_number),
        .i_col(i_column_number), .i_val(i_entry_value[VALUE_WIDTH-1:0]),
        .i_rows_lim(w_rows_lim), .i_cols_lim(w_cols_lim),
        .o_stat(w_stat), .o_count(o_nonzero_count)
    );

    `CSMU_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, start && !busy && !w_stat.range_err, busy)
    `CSMU_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy || $past(start))
    `CSMU_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, o_nonzero_count <= NW'(MAX_NONZEROS))
endmodule
